[src/lsa_pkg.sv]
`default_nettype none
package lsa_pkg;

	localparam int REGION_BYTES = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int ALIGN_BYTES  = 8;   // power of two

	localparam int ALIGN_SHIFT  = $clog2(ALIGN_BYTES);
	localparam int STORE_DEPTH  = REGION_BYTES / ALIGN_BYTES;
	localparam int SLOT_W       = $clog2(STORE_DEPTH);

	localparam int ADDR_W       = 13;
	localparam int REQ_W        = 16;
	localparam int TOTAL_W      = REQ_W + 2;

	localparam logic [ADDR_W-1:0] CAP_RESET = ADDR_W'(4096);

	typedef enum logic [1:0] {
		OP_ALLOC       = 2'd0,
		OP_FREE        = 2'd1,
		OP_GET_MARKER  = 2'd2,
		OP_FREE_MARKER = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_SPACE = 3'd1,
		ST_NOT_TOP  = 3'd2,
		ST_IGNORED  = 3'd3,
		ST_BAD_PTR  = 3'd4
	} status_t;

endpackage
`default_nettype wire

[src/lsa_if.sv]
`default_nettype none
interface lsa_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 op;
	logic [lsa_pkg::REQ_W-1:0]  request_bytes;
	logic [lsa_pkg::ADDR_W-1:0] block_pointer;
	logic                       pointer_is_null;
	logic [lsa_pkg::ADDR_W-1:0] marker;

	modport source (output valid, op, request_bytes, block_pointer, pointer_is_null, marker,
		input ready);
	modport sink (input valid, op, request_bytes, block_pointer, pointer_is_null, marker,
		output ready);
endinterface

interface lsa_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [2:0]                 status;
	logic [lsa_pkg::ADDR_W-1:0] result_address;
	logic [lsa_pkg::ADDR_W-1:0] used_level;

	modport source (output valid, status, result_address, used_level, input ready);
	modport sink (input valid, status, result_address, used_level, output ready);
endinterface
`default_nettype wire

[src/lifo_stack_allocator_core.sv]
// Timing: allocate, read marker and free back to marker give a registered result in the
//   cycle after acceptance; a free that reaches the header store first reads it (S_FREE).
// Throughput: one item at a time; up to 1 item/cycle for non-free ops while rsp.ready is
//   high; none in S_FREE. Reset (arst_n low): top cleared, capacity back to 4096, then a
//   512-entry header store clearing, with no item accepted (config writes still taken).
`default_nettype none
module lifo_stack_allocator_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [lsa_pkg::ADDR_W-1:0] cfg_wdata,
	lsa_req_if.sink                         req,
	lsa_rsp_if.source                       rsp
);

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_FREE} state_t;

	state_t                      state_q;
	logic [lsa_pkg::SLOT_W-1:0]  clr_idx_q;
	logic [lsa_pkg::ADDR_W-1:0]  top_q;
	logic [lsa_pkg::ADDR_W-1:0]  cap_q;
	logic [lsa_pkg::ADDR_W-1:0]  pos_s1;
	logic                        rsp_valid_q;
	lsa_pkg::status_t            status_q;
	logic [lsa_pkg::ADDR_W-1:0]  addr_q;
	logic [lsa_pkg::ADDR_W-1:0]  used_q;

	// header store
	logic [lsa_pkg::ADDR_W-1:0]  mem [lsa_pkg::STORE_DEPTH];
	logic [lsa_pkg::ADDR_W-1:0]  mem_rdata_q;
	logic                        mem_we;
	logic [lsa_pkg::SLOT_W-1:0]  mem_waddr;
	logic [lsa_pkg::ADDR_W-1:0]  mem_wdata;
	logic                        mem_re;

	lsa_pkg::op_t                op_c;
	logic                        accept;
	logic [lsa_pkg::ADDR_W-1:0]  cap_eff;
	logic [lsa_pkg::TOTAL_W-1:0] total_c;
	logic                        fits;
	logic                        alloc_slot_ok;
	logic [lsa_pkg::ADDR_W-1:0]  top_slot;
	logic [lsa_pkg::ADDR_W-1:0]  pos_c;
	logic [lsa_pkg::ADDR_W-1:0]  free_slot;
	logic                        free_bad;
	logic                        free_match;

	assign op_c    = lsa_pkg::op_t'(req.op);
	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept  = req.valid && req.ready;

	assign cap_eff = (cap_q > lsa_pkg::ADDR_W'(lsa_pkg::REGION_BYTES)) ?
		lsa_pkg::ADDR_W'(lsa_pkg::REGION_BYTES) : cap_q;

	// header added, then rounded up to the alignment
	assign total_c = (lsa_pkg::TOTAL_W'(req.request_bytes)
		+ lsa_pkg::TOTAL_W'(lsa_pkg::HEADER_BYTES + lsa_pkg::ALIGN_BYTES - 1))
		& ~lsa_pkg::TOTAL_W'(lsa_pkg::ALIGN_BYTES - 1);
	assign fits = (lsa_pkg::TOTAL_W'(top_q) + total_c) <= lsa_pkg::TOTAL_W'(cap_eff);

	assign top_slot      = top_q >> lsa_pkg::ALIGN_SHIFT;
	assign alloc_slot_ok = top_slot < lsa_pkg::ADDR_W'(lsa_pkg::STORE_DEPTH);

	assign pos_c     = req.block_pointer - lsa_pkg::ADDR_W'(lsa_pkg::HEADER_BYTES);
	assign free_slot = pos_c >> lsa_pkg::ALIGN_SHIFT;
	assign free_bad  = (req.block_pointer < lsa_pkg::ADDR_W'(lsa_pkg::HEADER_BYTES))
		|| ((pos_c & lsa_pkg::ADDR_W'(lsa_pkg::ALIGN_BYTES - 1)) != '0)
		|| (free_slot >= lsa_pkg::ADDR_W'(lsa_pkg::STORE_DEPTH));

	// S_FREE step of a free: block must end exactly at the top
	assign free_match = ({1'b0, pos_s1} + {1'b0, mem_rdata_q}) == {1'b0, top_q};

	always_comb begin
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
			mem_wdata = '0;
		end else begin
			mem_we    = accept && (op_c == lsa_pkg::OP_ALLOC) && fits && alloc_slot_ok;
			mem_waddr = top_slot[lsa_pkg::SLOT_W-1:0];
			mem_wdata = total_c[lsa_pkg::ADDR_W-1:0];
		end
	end

	assign mem_re = accept && (op_c == lsa_pkg::OP_FREE) && !req.pointer_is_null && !free_bad;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[free_slot[lsa_pkg::SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			top_q       <= '0;
			cap_q       <= lsa_pkg::CAP_RESET;
			pos_s1      <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= lsa_pkg::ST_OK;
			addr_q      <= '0;
			used_q      <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == lsa_pkg::SLOT_W'(lsa_pkg::STORE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: if (accept) begin
					rsp_valid_q <= 1'b1;
					status_q    <= lsa_pkg::ST_OK;
					addr_q      <= '0;
					used_q      <= top_q;
					case (op_c)
						lsa_pkg::OP_ALLOC: begin
							if (fits) begin
								addr_q <= top_q + lsa_pkg::ADDR_W'(lsa_pkg::HEADER_BYTES);
								top_q  <= top_q + total_c[lsa_pkg::ADDR_W-1:0];
								used_q <= top_q + total_c[lsa_pkg::ADDR_W-1:0];
							end else begin
								status_q <= lsa_pkg::ST_NO_SPACE;
							end
						end
						lsa_pkg::OP_FREE: begin
							if (req.pointer_is_null) begin
								status_q <= lsa_pkg::ST_IGNORED;
							end else if (free_bad) begin
								status_q <= lsa_pkg::ST_BAD_PTR;
							end else begin
								// wait for the stored size
								rsp_valid_q <= 1'b0;
								pos_s1      <= pos_c;
								state_q     <= S_FREE;
							end
						end
						lsa_pkg::OP_GET_MARKER: begin
							addr_q <= top_q;
						end
						lsa_pkg::OP_FREE_MARKER: begin
							if (req.marker <= top_q) begin
								top_q  <= req.marker;
								used_q <= req.marker;
							end else begin
								status_q <= lsa_pkg::ST_IGNORED;
							end
						end
						default: begin
							status_q <= lsa_pkg::ST_IGNORED;
						end
					endcase
				end
				S_FREE: begin
					rsp_valid_q <= 1'b1;
					addr_q      <= '0;
					state_q     <= S_IDLE;
					if (free_match) begin
						status_q <= lsa_pkg::ST_OK;
						top_q    <= pos_s1;
						used_q   <= pos_s1;
					end else begin
						status_q <= lsa_pkg::ST_NOT_TOP;
						used_q   <= top_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.result_address = addr_q;
	assign rsp.used_level     = used_q;

endmodule
`default_nettype wire

[src/lsa_core_chk.sv]
`default_nettype none
module lsa_core_chk (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_ready,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic [2:0]                 status,
	input wire logic [lsa_pkg::ADDR_W-1:0] result_address,
	input wire logic [lsa_pkg::ADDR_W-1:0] used_level
);

	// a waiting result stays until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// level can never pass the region
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> used_level <= lsa_pkg::ADDR_W'(lsa_pkg::REGION_BYTES))
		else $error("used level beyond region");

	// failed or ignored requests return no address
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != 3'(lsa_pkg::ST_OK)) |-> result_address == '0)
		else $error("address on a failed item");

	// a result taken with no new item leaves the output empty
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !(req_valid && req_ready) |=> !rsp_valid)
		else $error("result without an item");

endmodule

bind lifo_stack_allocator_core lsa_core_chk u_lsa_core_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.status         (rsp.status),
	.result_address (rsp.result_address),
	.used_level     (rsp.used_level)
);
`default_nettype wire

[tb/lifo_stack_allocator_core_test.sv]
module lifo_stack_allocator_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lsa_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT   = 10;
	localparam int PHASES         = 7;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// how a free or free-to-marker item picks its pointer once the stack state is known
	typedef enum logic [1:0] {PICK_NONE, PICK_TOP, PICK_ANY, PICK_MARK} pick_t;

	typedef struct packed {
		op_t               op;
		logic [REQ_W-1:0]  request_bytes;
		logic [ADDR_W-1:0] block_pointer;
		logic              pointer_is_null;
		logic [ADDR_W-1:0] marker;
		pick_t             pick;
	} alloc_req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [ADDR_W-1:0] result_address;
		logic [ADDR_W-1:0] used_level;
	} alloc_rsp_t;

	localparam int unsigned PHASE_CAPACITY [PHASES] = '{4096, 300, 8191, 4095, 0, 1024, 4096};
	localparam idle_mode_t  PHASE_IDLING [PHASES] =
		'{IDLE_SENDER, IDLE_RECEIVER, IDLE_NONE, IDLE_SENDER, IDLE_BOTH, IDLE_RECEIVER, IDLE_BOTH};
	localparam int          PHASE_ITEMS [PHASES] = '{100, 100, 100, 100, 60, 100, 100};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [ADDR_W-1:0] cfg_wdata;

	lsa_req_if req_ch();
	lsa_rsp_if rsp_ch();

	lifo_stack_allocator_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	int unsigned shadow_capacity;
	int unsigned shadow_top;
	int unsigned shadow_sizes [STORE_DEPTH];
	int unsigned live_blocks [$];

	alloc_req_t  pending_requests [$];
	alloc_req_t  held_request;
	alloc_rsp_t  predicted_results [$];
	alloc_rsp_t  wanted, seen;

	int          sender_gap_pct;
	int          receiver_stall_pct;
	int unsigned mismatches;
	int          idle_cycles;

	always #5 clk = ~clk;

	function automatic alloc_rsp_t compute_allocator_result(input alloc_req_t q);
		alloc_rsp_t  r;
		int unsigned total, limit, pos;
		r.status         = ST_OK;
		r.result_address = '0;
		limit = (shadow_capacity > REGION_BYTES) ? REGION_BYTES : shadow_capacity;
		case (q.op)
			OP_ALLOC: begin
				total = (q.request_bytes + HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
				if (shadow_top + total > limit) begin
					r.status = ST_NO_SPACE;
				end else begin
					// header slot sits below the top, even when the top is unaligned
					if (shadow_top / ALIGN_BYTES < STORE_DEPTH)
						shadow_sizes[shadow_top / ALIGN_BYTES] = total;
					r.result_address = ADDR_W'(shadow_top + HEADER_BYTES);
					live_blocks.push_back(shadow_top + HEADER_BYTES);
					shadow_top += total;
				end
			end
			OP_FREE: begin
				pos = q.block_pointer - HEADER_BYTES;
				if (q.pointer_is_null)
					r.status = ST_IGNORED;
				else if (q.block_pointer < HEADER_BYTES || pos % ALIGN_BYTES != 0 ||
						pos / ALIGN_BYTES >= STORE_DEPTH)
					r.status = ST_BAD_PTR;
				else if (pos + shadow_sizes[pos / ALIGN_BYTES] != shadow_top)
					r.status = ST_NOT_TOP;
				else
					shadow_top = pos;
			end
			OP_GET_MARKER: begin
				r.result_address = ADDR_W'(shadow_top);
			end
			OP_FREE_MARKER: begin
				if (q.marker <= shadow_top)
					shadow_top = q.marker;
				else
					r.status = ST_IGNORED;
			end
		endcase
		while (live_blocks.size() > 0 && live_blocks[$] >= shadow_top + HEADER_BYTES)
			void'(live_blocks.pop_back());
		r.used_level = ADDR_W'(shadow_top);
		return r;
	endfunction

	function automatic alloc_req_t complete_request(input alloc_req_t q);
		int unsigned n;
		n = live_blocks.size();
		case (q.pick)
			PICK_TOP: if (n > 0) q.block_pointer = ADDR_W'(live_blocks[n-1]);
			PICK_ANY: if (n > 0) q.block_pointer = ADDR_W'(live_blocks[$urandom_range(n-1)]);
			PICK_MARK: q.marker = (n > 0) ? ADDR_W'(live_blocks[$urandom_range(n-1)] - HEADER_BYTES) : '0;
			default: ;
		endcase
		return q;
	endfunction

	// value lands in the field the op uses; the rest are random filler
	task automatic add_request(input op_t op, input int unsigned value, input logic is_null,
			input pick_t pick);
		alloc_req_t q;
		q.op              = op;
		q.request_bytes   = REQ_W'($urandom);
		q.block_pointer   = ADDR_W'($urandom);
		q.pointer_is_null = (op == OP_FREE) ? is_null : 1'($urandom);
		q.marker          = ADDR_W'($urandom);
		q.pick            = pick;
		case (op)
			OP_ALLOC:       q.request_bytes = REQ_W'(value);
			OP_FREE:        if (!is_null) q.block_pointer = ADDR_W'(value);
			OP_FREE_MARKER: q.marker = ADDR_W'(value);
			default: ;
		endcase
		pending_requests.push_back(q);
	endtask

	task automatic add_random_requests(input int count);
		int unsigned roll, size_roll, value;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < 38) begin
				size_roll = $urandom_range(24);
				if (size_roll == 0)
					value = $urandom_range(65535);
				else if (size_roll < 4)
					value = $urandom_range(1000);
				else
					value = $urandom_range(120);
				add_request(OP_ALLOC, value, 1'b0, PICK_NONE);
			end else if (roll < 63) begin
				add_request(OP_FREE, 16, 1'b0, PICK_TOP);
			end else if (roll < 70) begin
				add_request(OP_FREE, 16, 1'b0, PICK_ANY);
			end else if (roll < 76) begin
				add_request(OP_FREE, 0, 1'b1, PICK_NONE);
			end else if (roll < 84) begin
				value = $urandom_range(1) ? $urandom_range(8191) : $urandom_range(63) * 8 + 16;
				add_request(OP_FREE, value, 1'b0, PICK_NONE);
			end else if (roll < 89) begin
				add_request(OP_GET_MARKER, 0, 1'b0, PICK_NONE);
			end else if (roll < 95) begin
				add_request(OP_FREE_MARKER, 0, 1'b0, PICK_MARK);
			end else begin
				value = $urandom_range(1) ? $urandom_range(8191) : $urandom_range(600);
				add_request(OP_FREE_MARKER, value, 1'b0, PICK_NONE);
			end
		end
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
			IDLE_SENDER:   begin sender_gap_pct = 54; receiver_stall_pct = 0;  end
			IDLE_RECEIVER: begin sender_gap_pct = 0;  receiver_stall_pct = 54; end
			IDLE_BOTH:     begin sender_gap_pct = 7;  receiver_stall_pct = 7;  end
		endcase
	endtask

	// checked on the falling edge, once the rising-edge updates have settled
	task automatic wait_until_quiet();
		@(negedge clk);
		while (pending_requests.size() > 0 || req_ch.valid || predicted_results.size() > 0)
			@(negedge clk);
	endtask

	task automatic write_capacity(input int unsigned value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= ADDR_W'(value);
		shadow_capacity = value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// request side: predicts on acceptance, then loads the next item from the queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predicted_results.push_back(compute_allocator_result(held_request));
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
					held_request = complete_request(pending_requests.pop_front());
					req_ch.valid           <= 1'b1;
					req_ch.op              <= held_request.op;
					req_ch.request_bytes   <= held_request.request_bytes;
					req_ch.block_pointer   <= held_request.block_pointer;
					req_ch.pointer_is_null <= held_request.pointer_is_null;
					req_ch.marker          <= held_request.marker;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen.status         = rsp_ch.status;
				seen.result_address = rsp_ch.result_address;
				seen.used_level     = rsp_ch.used_level;
				if (predicted_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected item: status %0d address %0d level %0d",
							seen.status, seen.result_address, seen.used_level);
				end else begin
					wanted = predicted_results.pop_front();
					if (seen.status !== wanted.status || seen.result_address !== wanted.result_address ||
							seen.used_level !== wanted.used_level) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("mismatch: status %0d/%0d address %0d/%0d level %0d/%0d (exp/got)",
								wanted.status, seen.status, wanted.result_address,
								seen.result_address, wanted.used_level, seen.used_level);
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = '0;
		req_ch.valid           = 1'b0;
		req_ch.op              = OP_ALLOC;
		req_ch.request_bytes   = '0;
		req_ch.block_pointer   = '0;
		req_ch.pointer_is_null = 1'b0;
		req_ch.marker          = '0;
		rsp_ch.ready           = 1'b0;
		sender_gap_pct         = 0;
		receiver_stall_pct     = 0;
		mismatches             = 0;
		idle_cycles            = 0;
		shadow_capacity        = CAP_RESET;
		shadow_top             = 0;
		foreach (shadow_sizes[i])
			shadow_sizes[i] = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty stack: marker, free of a never-written slot at the top, null free
		add_request(OP_GET_MARKER, 0, 1'b0, PICK_NONE);
		add_request(OP_FREE, 16, 1'b0, PICK_NONE);
		add_request(OP_FREE, 0, 1'b1, PICK_NONE);
		add_request(OP_ALLOC, 0, 1'b0, PICK_NONE);
		add_request(OP_ALLOC, 1, 1'b0, PICK_NONE);
		add_request(OP_ALLOC, 65535, 1'b0, PICK_NONE);
		add_request(OP_FREE, 16, 1'b0, PICK_NONE);    // not the top block
		// bad pointers: below header, unaligned, slot past the store; then a good free of the top block
		add_request(OP_FREE, 0, 1'b0, PICK_NONE);
		add_request(OP_FREE, 15, 1'b0, PICK_NONE);
		add_request(OP_FREE, 17, 1'b0, PICK_NONE);
		add_request(OP_FREE, 4112, 1'b0, PICK_NONE);
		add_request(OP_FREE, 8184, 1'b0, PICK_NONE);
		add_request(OP_FREE, 8191, 1'b0, PICK_NONE);
		add_request(OP_FREE, 32, 1'b0, PICK_NONE);
		add_request(OP_FREE_MARKER, 4096, 1'b0, PICK_NONE);
		add_request(OP_FREE_MARKER, 8191, 1'b0, PICK_NONE);
		add_request(OP_FREE_MARKER, 16, 1'b0, PICK_NONE);
		// unaligned marker, then a block that can only go back via the marker
		add_request(OP_FREE_MARKER, 3, 1'b0, PICK_NONE);
		add_request(OP_ALLOC, 5, 1'b0, PICK_NONE);
		add_request(OP_FREE, 19, 1'b0, PICK_NONE);
		add_request(OP_FREE_MARKER, 0, 1'b0, PICK_NONE);
		add_request(OP_ALLOC, 4080, 1'b0, PICK_NONE);  // exactly fills the region
		add_request(OP_ALLOC, 0, 1'b0, PICK_NONE);
		add_request(OP_GET_MARKER, 0, 1'b0, PICK_NONE);
		add_request(OP_FREE, 16, 1'b0, PICK_NONE);
		add_request(OP_ALLOC, 4081, 1'b0, PICK_NONE);
		add_random_requests(100);
		wait_until_quiet();

		for (int p = 0; p < PHASES; p++) begin
			// push the top up so a smaller capacity lands below it
			set_idling(IDLE_NONE);
			for (int i = 0; i < 8; i++)
				add_request(OP_ALLOC, $urandom_range(150, 250), 1'b0, PICK_NONE);
			wait_until_quiet();
			write_capacity(PHASE_CAPACITY[p]);
			set_idling(PHASE_IDLING[p]);
			add_random_requests(PHASE_ITEMS[p]);
			wait_until_quiet();
		end

		repeat (10) @(posedge clk);
		mismatches += predicted_results.size();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
src/lsa_pkg.sv
src/lsa_if.sv
src/lifo_stack_allocator_core.sv
src/lsa_core_chk.sv
tb/lifo_stack_allocator_core_test.sv
